>>> hw/rtl/tlvcmp_pkg.sv
// Shared types and constants for the TLV control message parser.
`timescale 1ns / 1ps
`default_nettype none
package tlvcmp_pkg;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    localparam logic [1:0] KIND_DNS_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DNS_ADDR  = 2'd1;
    localparam logic [1:0] KIND_PKT_DONE  = 2'd2;

    localparam logic [1:0] RPL_NONE    = 2'd0;
    localparam logic [1:0] RPL_CONFIG  = 2'd1;
    localparam logic [1:0] RPL_CONNECT = 2'd2;
    localparam logic [1:0] RPL_STATUS2 = 2'd3;

    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_CONFIGURE  = 2'd1;
    localparam logic [1:0] ACT_DISCONNECT = 2'd2;

    localparam logic [31:0] MSG_CONFIG_REQ  = 32'h6b;
    localparam logic [31:0] MSG_CONNECT_REQ = 32'h7d;
    localparam logic [31:0] MSG_STATUS2_REQ = 32'h6d;
    localparam logic [31:0] MSG_DISCONNECT  = 32'h6e;
    localparam logic [31:0] MSG_CONFIGURE   = 32'h71;

    localparam logic [15:0] OBJ_IFACE  = 16'h01;
    localparam logic [15:0] OBJ_DNS    = 16'h02;
    localparam logic [15:0] OBJ_MTU    = 16'h06;
    localparam logic [15:0] OBJ_REASON = 16'hcb;

    localparam logic [31:0] MTU_OVERHEAD = 32'd40;

    typedef struct packed {
        logic        has_dns;
        logic [1:0]  dns_kind;
        logic [31:0] dns_addr;
        logic        has_fin;
        logic [31:0] msg_code;
        logic [31:0] if_addr;
        logic [31:0] if_mask;
        logic [31:0] if_gw;
        logic [31:0] mtu;
        logic [31:0] reason;
    } t_evt;

endpackage
`default_nettype wire

>>> hw/rtl/tlvcmp_front.sv
// Byte parser: walks header, objects and elements and builds event records.
`timescale 1ns / 1ps
`default_nettype none
module tlvcmp_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_accept,
    input  wire  [7:0]         i_byte,
    output logic               o_push,
    output tlvcmp_pkg::t_evt   o_evt
);
    import tlvcmp_pkg::*;

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_OBJ_HDR   = 3'd1;
    localparam logic [2:0] PH_ELEM_HDR  = 3'd2;
    localparam logic [2:0] PH_ELEM_DATA = 3'd3;
    localparam logic [2:0] PH_ELEM_SKIP = 3'd4;
    localparam logic [2:0] PH_PKT_SKIP  = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_msg, n_msg;
    logic [31:0] r_pkt, n_pkt;
    logic [31:0] r_obj, n_obj;
    logic [15:0] r_id, n_id;
    logic [15:0] r_idx, n_idx;
    logic [31:0] r_elen, n_elen;
    logic [31:0] r_erem, n_erem;
    logic [31:0] r_val, n_val;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_gw, n_gw;
    logic [31:0] r_mtu, n_mtu;
    logic [31:0] r_reason, n_reason;

    logic        do_obj_next, do_pkt_next, do_fin, do_apply;
    logic        has_dns;
    logic [1:0]  dns_kind;
    logic [31:0] dns_addr;
    logic [31:0] v;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_msg = r_msg; n_pkt = r_pkt;
        n_obj = r_obj; n_id = r_id; n_idx = r_idx; n_elen = r_elen;
        n_erem = r_erem; n_val = r_val; n_addr = r_addr; n_mask = r_mask;
        n_gw = r_gw; n_mtu = r_mtu; n_reason = r_reason;
        do_obj_next = 1'b0; do_pkt_next = 1'b0; do_fin = 1'b0; do_apply = 1'b0;
        has_dns = 1'b0; dns_kind = KIND_DNS_CLEAR; dns_addr = '0; v = '0;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_cnt >= 5'd4 && r_cnt < 5'd8) begin
                    n_msg = {r_msg[23:0], i_byte};
                end else if (r_cnt >= 5'd16 && r_cnt < 5'd20) begin
                    n_pkt = {r_pkt[23:0], i_byte};
                end
                n_cnt = r_cnt + 5'd1;
                if (n_cnt >= 5'd20) begin
                    n_addr = '0; n_mask = '0; n_gw = '0; n_mtu = '0; n_reason = '0;
                    do_pkt_next = 1'b1;
                end
            end
            PH_OBJ_HDR: begin
                n_pkt = r_pkt - 32'd1;
                if (r_cnt < 5'd2) n_id = {r_id[7:0], i_byte};
                else              n_obj = {r_obj[23:0], i_byte};
                n_cnt = r_cnt + 5'd1;
                if (n_cnt >= 5'd6) begin
                    n_cnt = '0;
                    if (n_obj > n_pkt) begin
                        if (n_pkt == '0) do_fin = 1'b1;
                        else             n_phase = PH_PKT_SKIP;
                    end else begin
                        if (n_id == OBJ_DNS) begin
                            has_dns  = 1'b1;
                            dns_kind = KIND_DNS_CLEAR;
                        end else if (n_id == OBJ_REASON) begin
                            n_reason = '0;
                        end
                        do_obj_next = 1'b1;
                    end
                end
            end
            PH_ELEM_HDR: begin
                n_pkt = r_pkt - 32'd1;
                n_obj = r_obj - 32'd1;
                if (r_cnt < 5'd2) n_idx = {r_idx[7:0], i_byte};
                else              n_elen = {r_elen[23:0], i_byte};
                n_cnt = r_cnt + 5'd1;
                if (n_cnt >= 5'd6) begin
                    n_cnt = '0;
                    n_val = '0;
                    if (n_elen > n_obj) begin
                        if (n_obj == '0) do_obj_next = 1'b1;
                        else             n_phase = PH_ELEM_SKIP;
                    end else if (n_elen == '0) begin
                        do_apply = 1'b1;
                        do_obj_next = 1'b1;
                    end else begin
                        n_erem = n_elen;
                        n_phase = PH_ELEM_DATA;
                    end
                end
            end
            PH_ELEM_DATA: begin
                n_pkt = r_pkt - 32'd1;
                n_obj = r_obj - 32'd1;
                n_val = {r_val[23:0], i_byte};
                n_erem = r_erem - 32'd1;
                if (n_erem == '0) begin
                    do_apply = 1'b1;
                    do_obj_next = 1'b1;
                end
            end
            PH_ELEM_SKIP: begin
                n_pkt = r_pkt - 32'd1;
                n_obj = r_obj - 32'd1;
                if (n_obj == '0) do_obj_next = 1'b1;
            end
            PH_PKT_SKIP: begin
                n_pkt = r_pkt - 32'd1;
                if (n_pkt == '0) do_fin = 1'b1;
            end
            default: begin
                n_phase = PH_HEADER;
                n_cnt = '0;
            end
        endcase

        if (do_apply) begin
            v = (n_elen == 32'd4) ? n_val : 32'd0;
            unique case (n_id)
                OBJ_MTU: if (n_idx == 16'd2) n_mtu = v;
                OBJ_IFACE: begin
                    if (n_idx == 16'd1)      n_addr = v;
                    else if (n_idx == 16'd2) n_mask = v;
                    else if (n_idx == 16'd3) n_gw = v;
                end
                OBJ_DNS: begin
                    if (n_idx == 16'd1) begin
                        has_dns  = 1'b1;
                        dns_kind = KIND_DNS_ADDR;
                        dns_addr = v;
                    end
                end
                OBJ_REASON: if (n_idx == 16'd1) n_reason = v;
                default: ;
            endcase
        end

        if (do_obj_next) begin
            n_cnt = '0;
            if (n_obj == '0)        do_pkt_next = 1'b1;
            else if (n_obj < 32'd6) n_phase = PH_ELEM_SKIP;
            else                    n_phase = PH_ELEM_HDR;
        end
        if (do_pkt_next) begin
            n_cnt = '0;
            if (n_pkt == '0)        do_fin = 1'b1;
            else if (n_pkt < 32'd6) n_phase = PH_PKT_SKIP;
            else                    n_phase = PH_OBJ_HDR;
        end
        if (do_fin) begin
            n_phase = PH_HEADER;
            n_cnt = '0;
        end
    end

    always_comb begin
        o_push          = i_accept && (has_dns || do_fin);
        o_evt.has_dns   = has_dns;
        o_evt.dns_kind  = dns_kind;
        o_evt.dns_addr  = dns_addr;
        o_evt.has_fin   = do_fin;
        o_evt.msg_code  = n_msg;
        o_evt.if_addr   = n_addr;
        o_evt.if_mask   = n_mask;
        o_evt.if_gw     = n_gw;
        o_evt.mtu       = n_mtu;
        o_evt.reason    = n_reason;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_cnt <= '0; r_msg <= '0; r_pkt <= '0;
            r_obj <= '0; r_id <= '0; r_idx <= '0; r_elen <= '0; r_erem <= '0;
            r_val <= '0; r_addr <= '0; r_mask <= '0; r_gw <= '0; r_mtu <= '0;
            r_reason <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_msg <= n_msg; r_pkt <= n_pkt;
            r_obj <= n_obj; r_id <= n_id; r_idx <= n_idx; r_elen <= n_elen;
            r_erem <= n_erem; r_val <= n_val; r_addr <= n_addr; r_mask <= n_mask;
            r_gw <= n_gw; r_mtu <= n_mtu; r_reason <= n_reason;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/tlvcmp_queue.sv
// Event queue between the parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module tlvcmp_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  tlvcmp_pkg::t_evt   i_evt,
    input  wire                i_pop,
    output tlvcmp_pkg::t_evt   o_head,
    output logic               o_empty,
    output logic               o_full
);
    import tlvcmp_pkg::*;

    t_evt r_mem [QueueDepth];
    logic [QueueAw-1:0] r_wr, r_rd;
    logic [QueueAw:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QueueAw+1)'(QueueDepth));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (QueueAw+1)'(i_push) - (QueueAw+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QueueAw+1)'(QueueDepth)) else $error("queue count out of range");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance");

endmodule
`default_nettype wire

>>> hw/rtl/tlvcmp_back.sv
// Output stage: splits queued events into result beats.
`timescale 1ns / 1ps
`default_nettype none
module tlvcmp_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  tlvcmp_pkg::t_evt   i_head,
    input  wire                i_empty,
    output logic               o_pop,
    input  wire                i_m_tready,
    output logic               o_m_tvalid,
    output logic [1:0]         o_kind,
    output logic [31:0]        o_dns_addr,
    output logic [31:0]        o_msg_code,
    output logic [1:0]         o_req,
    output logic [1:0]         o_act,
    output logic [31:0]        o_if_addr,
    output logic [31:0]        o_if_mask,
    output logic [31:0]        o_if_gw,
    output logic [31:0]        o_mtu,
    output logic [31:0]        o_reason,
    output logic               o_last
);
    import tlvcmp_pkg::*;

    logic        r_valid, r_half;
    logic        load, take_dns;
    logic [1:0]  req, act;

    assign load     = !r_valid || i_m_tready;
    assign take_dns = i_head.has_dns && !r_half;
    assign o_pop    = load && !i_empty && !(take_dns && i_head.has_fin);
    assign o_m_tvalid = r_valid;

    always_comb begin
        req = RPL_NONE;
        act = ACT_NONE;
        if (i_head.msg_code == MSG_CONFIG_REQ)       req = RPL_CONFIG;
        else if (i_head.msg_code == MSG_CONNECT_REQ) req = RPL_CONNECT;
        else if (i_head.msg_code == MSG_STATUS2_REQ) req = RPL_STATUS2;
        else if (i_head.msg_code == MSG_DISCONNECT)  act = ACT_DISCONNECT;
        else if (i_head.msg_code == MSG_CONFIGURE)   act = ACT_CONFIGURE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) r_half <= take_dns && i_head.has_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            if (take_dns) begin
                o_kind <= i_head.dns_kind;
                o_dns_addr <= i_head.dns_addr;
                o_msg_code <= '0; o_req <= RPL_NONE; o_act <= ACT_NONE;
                o_if_addr <= '0; o_if_mask <= '0; o_if_gw <= '0;
                o_mtu <= '0; o_reason <= '0;
                o_last <= !i_head.has_fin;
            end else begin
                o_kind <= KIND_PKT_DONE;
                o_dns_addr <= '0;
                o_msg_code <= i_head.msg_code; o_req <= req; o_act <= act;
                o_if_addr <= i_head.if_addr; o_if_mask <= i_head.if_mask;
                o_if_gw <= i_head.if_gw;
                o_mtu <= i_head.mtu - MTU_OVERHEAD;
                o_reason <= i_head.reason;
                o_last <= 1'b1;
            end
        end
    end

    a_half_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> !i_empty) else $error("split event lost its entry");
    a_half_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_half && r_valid) |-> !o_last) else $error("first half marked last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_m_tready) |=> r_valid) else $error("beat dropped");

endmodule
`default_nettype wire

>>> hw/rtl/tlv_control_message_parser_top.sv
// Top level of the TLV control message parser.
`timescale 1ns / 1ps
`default_nettype none
// Takes one control-stream byte per beat and returns dns-clear, dns-address
// and packet-finished events. A byte is taken every cycle while the 4-entry
// event queue has room; a byte that yields two events needs two output beats,
// so the input stalls only when the output side falls behind. The event is
// queued at the edge that accepts the byte and then loaded into the output
// register once that register is free and the event is at the queue head.
module tlv_control_message_parser_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,   // in_byte
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [231:0] m_tdata,   // dns_address, message_type, reply_request, action,
                                    // if_address, if_netmask, if_gateway, tunnel_mtu,
                                    // disconnect_reason, zero pad
    output logic [1:0]   m_tuser,   // event_kind
    output logic         m_tlast    // last
);
    import tlvcmp_pkg::*;

    t_evt        evt, head;
    logic        push, pop, empty, full, accept;
    logic [31:0] dns_addr, msg_code, if_addr, if_mask, if_gw, mtu, reason;
    logic [1:0]  req, act;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    tlvcmp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_byte(s_tdata),
        .o_push(push), .o_evt(evt)
    );

    tlvcmp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_evt(evt),
        .i_pop(pop), .o_head(head), .o_empty(empty), .o_full(full)
    );

    tlvcmp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(head), .i_empty(empty),
        .o_pop(pop), .i_m_tready(m_tready), .o_m_tvalid(m_tvalid),
        .o_kind(m_tuser), .o_dns_addr(dns_addr), .o_msg_code(msg_code),
        .o_req(req), .o_act(act), .o_if_addr(if_addr), .o_if_mask(if_mask),
        .o_if_gw(if_gw), .o_mtu(mtu), .o_reason(reason), .o_last(m_tlast)
    );

    assign m_tdata = {4'b0, reason, mtu, if_gw, if_mask, if_addr, act, req,
                      msg_code, dns_addr};

endmodule
`default_nettype wire
